// File: hdl/tdv_pkg.sv
// Tom drum voice: shared constants, codes and types.
// No dependencies; imported by every tdv module and the testbench.
`default_nettype none
package tdv_pkg;

   localparam int ENV_W  = 25;
   localparam int MUL_W  = 32;
   localparam int DIV_W  = 64;
   localparam int FREQ_W = 25;

   localparam logic [ENV_W-1:0]  ONE_Q24       = 25'h100_0000;
   localparam logic [15:0]       GAIN_Q16      = 16'd45875;
   localparam logic [15:0]       FADE_Q16      = 16'd62259;
   localparam logic [DIV_W-1:0]  AMP_NUM       = 64'd83886080000;
   localparam logic [DIV_W-1:0]  PITCH_NUM     = 64'd167772160000;
   localparam logic [FREQ_W-1:0] BASE_FREQ_Q16 = 25'd5242880;

   localparam logic [1:0] MODE_TICK    = 2'd0;
   localparam logic [1:0] MODE_TRIGGER = 2'd1;
   localparam logic [1:0] MODE_SILENCE = 2'd2;

   localparam logic [2:0] CSR_TUNE        = 3'd0;
   localparam logic [2:0] CSR_AMP_DECAY   = 3'd1;
   localparam logic [2:0] CSR_SWEEP_DEPTH = 3'd2;
   localparam logic [2:0] CSR_SWEEP_DECAY = 3'd3;
   localparam logic [2:0] CSR_SILENCE     = 3'd4;

   localparam logic [15:0] TUNE_RST        = 16'd32768;
   localparam logic [13:0] AMP_DECAY_RST   = 14'd300;
   localparam logic [15:0] SWEEP_DEPTH_RST = 16'd32768;
   localparam logic [15:0] SWEEP_DECAY_RST = 16'd500;
   localparam logic [15:0] SILENCE_RST     = 16'd1678;

   typedef struct packed {
      logic busy;
      logic done;
   } tdv_unit_status_type;

endpackage
`default_nettype wire

// File: hdl/tdv_if.sv
// Tom drum voice: request and response channel interfaces.
// No dependencies.
`default_nettype none
interface tdv_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [15:0] velocity;
   modport source (output valid, mode, velocity, input ready);
   modport sink (input valid, mode, velocity, output ready);
endinterface

interface tdv_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample;
   logic               active;
   modport source (output valid, sample, active, input ready);
   modport sink (input valid, sample, active, output ready);
endinterface
`default_nettype wire

// File: hdl/tdv_serial_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on tdv_pkg.
`default_nettype none
module tdv_serial_mul
   import tdv_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [MUL_W-1:0]     a,
   input  wire logic [MUL_W-1:0]     b,
   output logic      [2*MUL_W-1:0]   product,
   output tdv_unit_status_type       status
);

   localparam int CNT_W = $clog2(MUL_W);

   logic [MUL_W-1:0]   a_ff, a_in;
   logic [2*MUL_W-1:0] p_ff, p_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [MUL_W:0]     part_sum;

   always_comb begin
      a_in     = a_ff;
      p_in     = p_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      part_sum = {1'b0, p_ff[2*MUL_W-1:MUL_W]} + (p_ff[0] ? {1'b0, a_ff} : '0);
      if (start) begin
         a_in    = a;
         p_in    = {{MUL_W{1'b0}}, b};
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         p_in   = {part_sum, p_ff[MUL_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(MUL_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      p_ff   <= p_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign product     = p_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule
`default_nettype wire

// File: hdl/tdv_serial_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on tdv_pkg.
`default_nettype none
module tdv_serial_div
   import tdv_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DIV_W-1:0] numerator,
   input  wire logic [DIV_W-1:0] denominator,
   output logic      [DIV_W-1:0] quotient,
   output tdv_unit_status_type   status
);

   localparam int CNT_W = $clog2(DIV_W);

   logic [DIV_W-1:0] n_ff, n_in;
   logic [DIV_W-1:0] r_ff, r_in;
   logic [DIV_W-1:0] d_ff, d_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DIV_W+1:0] trial;
   logic             fits;

   always_comb begin
      n_in    = n_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {1'b0, r_ff, n_ff[DIV_W-1]} - {2'b00, d_ff};
      fits    = ~trial[DIV_W+1];
      if (start) begin
         n_in    = numerator;
         r_in    = '0;
         d_in    = denominator;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         r_in   = fits ? trial[DIV_W-1:0] : {r_ff[DIV_W-2:0], n_ff[DIV_W-1]};
         n_in   = {n_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient    = n_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule
`default_nettype wire

// File: hdl/tdv_sine_rom.sv
// Q1.15 sine table, built at elaboration by a quarter-wave Q30 Taylor series.
// Registered read. Depends on tdv_pkg only through the project import.
`default_nettype none
module tdv_sine_rom
   import tdv_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int IDX_W = 10
) (
   input  wire logic              clock,
   input  wire logic [IDX_W-1:0]  addr,
   output logic signed [15:0]     data
);

   localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
   localparam logic [63:0] QTR_Q30    = 64'h1000_0000;
   localparam logic [63:0] HALF_Q30   = 64'h2000_0000;

   typedef logic signed [15:0] sine_tab_type [DEPTH];

   function automatic logic signed [15:0] sine_entry(input logic [31:0] i);
      logic [63:0]        u;
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic [63:0]        t;
      logic signed [63:0] sum;
      logic [63:0]        v;
      logic               neg;
      u   = ({32'd0, i} << 30) / 64'(DEPTH);
      neg = 1'b0;
      sum = '0;
      if (u >= HALF_Q30) begin
         neg = 1'b1;
         u   = u - HALF_Q30;
      end
      if (u > QTR_Q30) u = HALF_Q30 - u;
      x    = (u * TWO_PI_Q30) >> 30;
      x2   = (x * x) >> 30;
      term = x;
      for (int k = 0; k < 6; k++) begin
         if (k % 2 == 1) sum = sum - $signed(term);
         else sum = sum + $signed(term);
         t = (term * x2) >> 30;
         case (k)
            0: term = t / 64'd6;
            1: term = t / 64'd20;
            2: term = t / 64'd42;
            3: term = t / 64'd72;
            4: term = t / 64'd110;
            default: term = t / 64'd156;
         endcase
      end
      if (sum < 0) sum = '0;
      v = ($unsigned(sum) + 64'd16384) >> 15;
      if (v > 64'd32767) v = 64'd32767;
      return neg ? -$signed(v[15:0]) : $signed(v[15:0]);
   endfunction

   function automatic sine_tab_type build_tab();
      sine_tab_type tab;
      for (int i = 0; i < DEPTH; i++) tab[i] = sine_entry(32'(i));
      return tab;
   endfunction

   localparam sine_tab_type SINE_TAB = build_tab();

   logic signed [15:0] data_ff;

   always_ff @(posedge clock) begin
      data_ff <= SINE_TAB[addr];
   end

   assign data = data_ff;

endmodule
`default_nettype wire

// File: hdl/tom_drum_voice.sv
// Tom drum voice top level: sequencer, voice state and configuration.
// Depends on tdv_pkg, tdv_if, tdv_serial_mul, tdv_serial_div, tdv_sine_rom.
// Trigger, voice reset and ignored modes are handled in the idle state and give no result;
// a tick on a silent voice goes straight to the response state. A sounding tick computes
// eight products on the 32-bit bit-serial multiplier and three quotients on the 64-bit
// bit-serial divider, in order, then loads the response once the response channel is
// free, one transaction at a time. Synchronous active-high reset clears voice state and
// loads the configuration defaults.
`default_nettype none
module tom_drum_voice
   import tdv_pkg::*;
#(
   parameter int SAMPLE_RATE      = 48000,
   parameter int SINE_TABLE_DEPTH = 1024,
   parameter int PHASE_BITS       = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   tdv_req_if.sink          req_ch,
   tdv_rsp_if.source        rsp_ch,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
   localparam int SR_W  = $clog2(SAMPLE_RATE + 1);
   localparam int DEN_W = 16 + SR_W + 2;
   localparam logic [63:0] ATK_STEP_L =
      (64'd16777216 * 64'd2000 + 64'(SAMPLE_RATE / 2)) / 64'(SAMPLE_RATE);
   localparam logic [ENV_W-1:0] ATK_STEP = ENV_W'(ATK_STEP_L);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_G1    = 4'd1;
   localparam logic [3:0] ST_G2    = 4'd2;
   localparam logic [3:0] ST_G3    = 4'd3;
   localparam logic [3:0] ST_SINE  = 4'd4;
   localparam logic [3:0] ST_FADE  = 4'd5;
   localparam logic [3:0] ST_SWEEP = 4'd6;
   localparam logic [3:0] ST_STEP  = 4'd7;
   localparam logic [3:0] ST_ADIV  = 4'd8;
   localparam logic [3:0] ST_AMUL  = 4'd9;
   localparam logic [3:0] ST_PDIV  = 4'd10;
   localparam logic [3:0] ST_PMUL  = 4'd11;
   localparam logic [3:0] ST_DONE  = 4'd12;

   logic [3:0]             state_ff, state_in;
   logic                   wait_ff, wait_in;
   logic                   quiet_ff, quiet_in;
   logic [PHASE_BITS-1:0]  phase_ff, phase_in;
   logic [ENV_W-1:0]       amp_ff, amp_in;
   logic [ENV_W-1:0]       atk_ff, atk_in;
   logic [ENV_W-1:0]       pitch_ff, pitch_in;
   logic [ENV_W-1:0]       g_ff, g_in;
   logic [ENV_W-1:0]       coef_ff, coef_in;
   logic [FREQ_W-1:0]      freq_ff, freq_in;
   logic signed [15:0]     offset_ff, offset_in;
   logic signed [15:0]     prev_ff, prev_in;
   logic signed [15:0]     sample_ff, sample_in;
   logic [15:0]            strike_ff, strike_in;
   logic                   sounding_ff, sounding_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]     rsp_sample_ff, rsp_sample_in;
   logic                   rsp_active_ff, rsp_active_in;
   logic [15:0]            tune_ff, tune_in;
   logic [13:0]            amp_ms_ff, amp_ms_in;
   logic [15:0]            depth_ff, depth_in;
   logic [15:0]            units_ff, units_in;
   logic [15:0]            silence_ff, silence_in;

   logic                   mul_start, div_start;
   logic [MUL_W-1:0]       mul_a, mul_b;
   logic [2*MUL_W-1:0]     mul_prod;
   tdv_unit_status_type    mul_stat, div_stat;
   logic [DIV_W-1:0]       div_num, div_den, div_quot;
   logic signed [15:0]     sine_q;
   logic                   is_mul_st, is_div_st, op_done, req_take;

   logic [13:0]            ms_eff;
   logic [15:0]            units_eff;
   logic [DEN_W-1:0]       amp_den, pitch_den;
   logic [15:0]            sine_mag;
   logic signed [16:0]     off_ext;
   logic [16:0]            off_mag;
   logic [23:0]            depth200;
   logic [15:0]            scaled_mag;
   logic signed [17:0]     scaled, mix_sum;
   logic [15:0]            fade_mag;
   logic [ENV_W:0]         atk_sum;
   logic signed [16:0]     smp_ext;
   logic [16:0]            smp_mag;
   logic [25:0]            smp_cmp;
   logic                   fade_out;

   tdv_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .product (mul_prod),
      .status  (mul_stat)
   );

   tdv_serial_div u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (div_num),
      .denominator (div_den),
      .quotient    (div_quot),
      .status      (div_stat)
   );

   tdv_sine_rom #(
      .DEPTH (SINE_TABLE_DEPTH),
      .IDX_W (IDX_W)
   ) u_rom (
      .clock (clock),
      .addr  (phase_ff[PHASE_BITS-1 -: IDX_W]),
      .data  (sine_q)
   );

   assign ms_eff    = (amp_ms_ff == 14'd0) ? 14'd1 : amp_ms_ff;
   assign units_eff = (units_ff < 16'd10) ? 16'd10 : units_ff;
   assign amp_den   = DEN_W'(ms_eff) * DEN_W'(4 * SAMPLE_RATE);
   assign pitch_den = DEN_W'(units_eff) * DEN_W'(SAMPLE_RATE);
   assign sine_mag  = sine_q[15] ? 16'(-sine_q) : 16'(sine_q);
   assign off_ext   = {offset_ff[15], offset_ff};
   assign off_mag   = offset_ff[15] ? 17'(-off_ext) : 17'(off_ext);
   assign depth200  = 24'(depth_ff) * 24'd200;

   assign is_mul_st = (state_ff == ST_G1) || (state_ff == ST_G2) || (state_ff == ST_G3) ||
                      (state_ff == ST_SINE) || (state_ff == ST_FADE) ||
                      (state_ff == ST_SWEEP) || (state_ff == ST_AMUL) ||
                      (state_ff == ST_PMUL);
   assign is_div_st = (state_ff == ST_STEP) || (state_ff == ST_ADIV) ||
                      (state_ff == ST_PDIV);
   assign mul_start = is_mul_st && !wait_ff;
   assign div_start = is_div_st && !wait_ff;
   assign op_done   = wait_ff && ((is_mul_st && mul_stat.done) ||
                                  (is_div_st && div_stat.done));

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;

   always_comb begin
      case (state_ff)
         ST_G1:   begin mul_a = MUL_W'(amp_ff);     mul_b = MUL_W'(atk_ff);    end
         ST_G2:   begin mul_a = MUL_W'(g_ff);       mul_b = MUL_W'(strike_ff); end
         ST_G3:   begin mul_a = MUL_W'(g_ff);       mul_b = MUL_W'(GAIN_Q16);  end
         ST_SINE: begin mul_a = MUL_W'(sine_mag);   mul_b = MUL_W'(g_ff);      end
         ST_FADE: begin mul_a = MUL_W'(off_mag);    mul_b = MUL_W'(FADE_Q16);  end
         ST_SWEEP: begin mul_a = MUL_W'(depth200);  mul_b = MUL_W'(pitch_ff);  end
         ST_AMUL: begin mul_a = MUL_W'(amp_ff);     mul_b = MUL_W'(coef_ff);   end
         ST_PMUL: begin mul_a = MUL_W'(pitch_ff);   mul_b = MUL_W'(coef_ff);   end
         default: begin mul_a = '0;                 mul_b = '0;                end
      endcase
      case (state_ff)
         ST_STEP: begin
            div_num = DIV_W'(freq_ff) << (PHASE_BITS - 16);
            div_den = DIV_W'(SAMPLE_RATE);
         end
         ST_ADIV: begin
            div_num = AMP_NUM + DIV_W'(amp_den >> 1);
            div_den = DIV_W'(amp_den);
         end
         ST_PDIV: begin
            div_num = PITCH_NUM + DIV_W'(pitch_den >> 1);
            div_den = DIV_W'(pitch_den);
         end
         default: begin
            div_num = '0;
            div_den = '0;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      wait_in       = wait_ff;
      quiet_in      = quiet_ff;
      phase_in      = phase_ff;
      amp_in        = amp_ff;
      atk_in        = atk_ff;
      pitch_in      = pitch_ff;
      g_in          = g_ff;
      coef_in       = coef_ff;
      freq_in       = freq_ff;
      offset_in     = offset_ff;
      prev_in       = prev_ff;
      sample_in     = sample_ff;
      strike_in     = strike_ff;
      sounding_in   = sounding_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_active_in = rsp_active_ff;
      tune_in       = tune_ff;
      amp_ms_in     = amp_ms_ff;
      depth_in      = depth_ff;
      units_in      = units_ff;
      silence_in    = silence_ff;

      scaled_mag = mul_prod[39:24];
      scaled     = sine_q[15] ? -$signed({2'b00, scaled_mag}) : $signed({2'b00, scaled_mag});
      mix_sum    = scaled + 18'(offset_ff);
      fade_mag   = mul_prod[31:16];
      atk_sum    = {1'b0, atk_ff} + {1'b0, ATK_STEP};
      smp_ext    = {sample_ff[15], sample_ff};
      smp_mag    = sample_ff[15] ? 17'(-smp_ext) : 17'(smp_ext);
      smp_cmp    = {smp_mag, 9'd0};
      fade_out   = (amp_ff < ENV_W'(silence_ff)) && (smp_cmp < 26'(silence_ff));

      if (csr_we) begin
         case (csr_index)
            CSR_TUNE:        tune_in    = csr_wdata;
            CSR_AMP_DECAY:   amp_ms_in  = csr_wdata[13:0];
            CSR_SWEEP_DEPTH: depth_in   = csr_wdata;
            CSR_SWEEP_DECAY: units_in   = csr_wdata;
            CSR_SILENCE:     silence_in = csr_wdata;
            default: ;
         endcase
      end

      if (mul_start || div_start) wait_in = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req_ch.mode)
                  MODE_TRIGGER: begin
                     offset_in   = prev_ff;
                     strike_in   = req_ch.velocity;
                     amp_in      = ONE_Q24;
                     atk_in      = '0;
                     pitch_in    = ONE_Q24;
                     phase_in    = '0;
                     sounding_in = 1'b1;
                  end
                  MODE_SILENCE: begin
                     sounding_in = 1'b0;
                     amp_in      = '0;
                     prev_in     = '0;
                     offset_in   = '0;
                  end
                  MODE_TICK: begin
                     quiet_in = !sounding_ff;
                     state_in = sounding_ff ? ST_G1 : ST_DONE;
                  end
                  default: ;
               endcase
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (quiet_ff) begin
                  rsp_sample_in = '0;
                  rsp_active_in = 1'b0;
                  prev_in       = '0;
               end else begin
                  rsp_sample_in = sample_ff;
                  prev_in       = sample_ff;
                  rsp_active_in = !fade_out;
                  if (fade_out) begin
                     sounding_in = 1'b0;
                     amp_in      = '0;
                     offset_in   = '0;
                  end
               end
            end
         end
         default: begin
            if (op_done) begin
               wait_in = 1'b0;
               case (state_ff)
                  ST_G1: begin
                     g_in     = mul_prod[48:24];
                     state_in = ST_G2;
                  end
                  ST_G2: begin
                     g_in     = mul_prod[40:16];
                     state_in = ST_G3;
                  end
                  ST_G3: begin
                     g_in     = mul_prod[40:16];
                     state_in = ST_SINE;
                  end
                  ST_SINE: begin
                     if (mix_sum > 18'sd32767) sample_in = 16'sh7fff;
                     else if (mix_sum < -18'sd32768) sample_in = 16'sh8000;
                     else sample_in = mix_sum[15:0];
                     state_in = ST_FADE;
                  end
                  ST_FADE: begin
                     offset_in = offset_ff[15] ? -$signed(fade_mag) : $signed(fade_mag);
                     state_in  = ST_SWEEP;
                  end
                  ST_SWEEP: begin
                     freq_in  = BASE_FREQ_Q16 + FREQ_W'(tune_ff) * FREQ_W'(150) +
                                FREQ_W'(mul_prod[47:24]);
                     state_in = ST_STEP;
                  end
                  ST_STEP: begin
                     phase_in = phase_ff + div_quot[PHASE_BITS-1:0];
                     atk_in   = (atk_sum > {1'b0, ONE_Q24}) ? ONE_Q24 : atk_sum[ENV_W-1:0];
                     state_in = ST_ADIV;
                  end
                  ST_ADIV: begin
                     coef_in  = (div_quot >= DIV_W'(ONE_Q24)) ? '0 :
                                ONE_Q24 - div_quot[ENV_W-1:0];
                     state_in = ST_AMUL;
                  end
                  ST_AMUL: begin
                     amp_in   = mul_prod[48:24];
                     state_in = ST_PDIV;
                  end
                  ST_PDIV: begin
                     coef_in  = (div_quot >= DIV_W'(ONE_Q24)) ? '0 :
                                ONE_Q24 - div_quot[ENV_W-1:0];
                     state_in = ST_PMUL;
                  end
                  ST_PMUL: begin
                     pitch_in = mul_prod[48:24];
                     state_in = ST_DONE;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      g_ff          <= g_in;
      coef_ff       <= coef_in;
      freq_ff       <= freq_in;
      sample_ff     <= sample_in;
      strike_ff     <= strike_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_active_ff <= rsp_active_in;
      quiet_ff      <= quiet_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         wait_ff      <= 1'b0;
         phase_ff     <= '0;
         amp_ff       <= '0;
         atk_ff       <= '0;
         pitch_ff     <= '0;
         offset_ff    <= '0;
         prev_ff      <= '0;
         sounding_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tune_ff      <= TUNE_RST;
         amp_ms_ff    <= AMP_DECAY_RST;
         depth_ff     <= SWEEP_DEPTH_RST;
         units_ff     <= SWEEP_DECAY_RST;
         silence_ff   <= SILENCE_RST;
      end else begin
         state_ff     <= state_in;
         wait_ff      <= wait_in;
         phase_ff     <= phase_in;
         amp_ff       <= amp_in;
         atk_ff       <= atk_in;
         pitch_ff     <= pitch_in;
         offset_ff    <= offset_in;
         prev_ff      <= prev_in;
         sounding_ff  <= sounding_in;
         rsp_valid_ff <= rsp_valid_in;
         tune_ff      <= tune_in;
         amp_ms_ff    <= amp_ms_in;
         depth_ff     <= depth_in;
         units_ff     <= units_in;
         silence_ff   <= silence_in;
      end
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.sample = rsp_sample_ff;
   assign rsp_ch.active = rsp_active_ff;

`ifndef SYNTHESIS
   a_mul_idle: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> !mul_stat.busy) else $error("multiplier restarted while busy");
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy) else $error("divider restarted while busy");
   a_silent_env: assert property (@(posedge clock) disable iff (reset)
      !sounding_ff |-> amp_ff == '0) else $error("amplitude left on a silent voice");
   a_atk_cap: assert property (@(posedge clock) disable iff (reset)
      atk_ff <= ONE_Q24) else $error("attack envelope above unity");
   a_trigger: assert property (@(posedge clock) disable iff (reset)
      req_take && req_ch.mode == MODE_TRIGGER |=> sounding_ff && pitch_ff == ONE_Q24)
      else $error("trigger transaction did not start the voice");
`endif

endmodule
`default_nettype wire

// File: sim/tb_top.sv
// Tom drum voice testbench: directed table then random transactions, each result checked
// against the table or a bit-accurate predictor. Depends on tdv_pkg, tdv_if, tom_drum_voice.
`default_nettype none
module tb_top
   import tdv_pkg::*;
;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               active;
   } voice_out_type;

   typedef struct {
      logic [1:0]         mode;
      logic [15:0]        velocity;
      bit                 typed;
      logic signed [15:0] sample;
      logic               active;
   } stim_row_type;

   localparam longint unsigned RATE = 48000;
   localparam longint unsigned ONE = 64'd16777216;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   tdv_req_if req_ch ();
   tdv_rsp_if rsp_ch ();

   tom_drum_voice i_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   // predictor state
   int sine_rom [1024];
   logic [31:0] phase_q;
   logic [24:0] amp_q, atk_q, pitch_q;
   logic signed [15:0] offset_q, prev_q;
   logic [15:0] strike_q;
   bit sounding_q;
   logic [15:0] tune_r, depth_r, sweep_r, silence_r;
   logic [13:0] amp_ms_r;

   voice_out_type samples_due [$];
   int mismatches = 0;
   bit quiet_rsp = 0;
   int rsp_wait = 0;

   function automatic int sine_value(int i);
      longint unsigned u, x, x2, term, v;
      longint sum;
      bit neg;
      u = (longint'(i) << 30) / 1024;
      neg = 0;
      sum = 0;
      if (u >= (64'd1 << 29)) begin
         neg = 1;
         u -= (64'd1 << 29);
      end
      if (u > (64'd1 << 28)) u = (64'd1 << 29) - u;
      x = (u * 64'd6746518852) >> 30;
      x2 = (x * x) >> 30;
      term = x;
      for (int k = 0; k < 6; k++) begin
         if (k % 2) sum -= longint'(term); else sum += longint'(term);
         term = ((term * x2) >> 30) / longint'((2 * k + 2) * (2 * k + 3));
      end
      if (sum < 0) sum = 0;
      v = (longint'(sum) + 16384) >> 15;
      if (v > 32767) v = 32767;
      return neg ? -int'(v) : int'(v);
   endfunction

   function automatic longint scale_mag(longint v, longint unsigned g, int sh);
      longint unsigned m;
      m = ((v < 0 ? -v : v) * g) >> sh;
      return v < 0 ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint unsigned coef(longint unsigned num, longint unsigned den);
      longint unsigned d;
      d = (num + den / 2) / den;
      if (d > ONE) d = ONE;
      return ONE - d;
   endfunction

   task automatic voice_reset_model();
      phase_q = '0; amp_q = '0; atk_q = '0; pitch_q = '0;
      offset_q = '0; prev_q = '0; strike_q = '0; sounding_q = 0;
      tune_r = TUNE_RST; amp_ms_r = AMP_DECAY_RST; depth_r = SWEEP_DEPTH_RST;
      sweep_r = SWEEP_DECAY_RST; silence_r = SILENCE_RST;
   endtask

   task automatic voice_step(input logic [1:0] mode, input logic [15:0] vel,
                             output bit has_out, output voice_out_type res);
      longint unsigned g, fq, stp, atk, ms, units, mag;
      longint s;
      has_out = 0;
      res = '0;
      if (mode == MODE_TRIGGER) begin
         offset_q = prev_q; strike_q = vel;
         amp_q = 25'(ONE); atk_q = '0; pitch_q = 25'(ONE); phase_q = '0; sounding_q = 1;
      end else if (mode == MODE_SILENCE) begin
         sounding_q = 0; amp_q = '0; prev_q = '0; offset_q = '0;
      end else if (mode == MODE_TICK) begin
         has_out = 1;
         if (!sounding_q) begin
            prev_q = '0;
         end else begin
            g = (longint'(amp_q) * atk_q) >> 24;
            g = (g * strike_q) >> 16;
            g = (g * GAIN_Q16) >> 16;
            s = scale_mag(sine_rom[phase_q[31:22]], g, 24) + offset_q;
            if (s > 32767) s = 32767;
            if (s < -32768) s = -32768;
            offset_q = 16'(scale_mag(offset_q, FADE_Q16, 16));
            fq = (64'd80 << 16) + 150 * longint'(tune_r) +
                 ((200 * longint'(depth_r) * pitch_q) >> 24);
            stp = (fq << 16) / RATE;
            phase_q = phase_q + stp[31:0];
            atk = atk_q + (ONE * 2000 + RATE / 2) / RATE;
            atk_q = 25'(atk > ONE ? ONE : atk);
            ms = amp_ms_r < 1 ? 1 : amp_ms_r;
            units = sweep_r < 10 ? 10 : sweep_r;
            amp_q = 25'((longint'(amp_q) * coef(ONE * 5000, ms * RATE * 4)) >> 24);
            pitch_q = 25'((longint'(pitch_q) * coef(ONE * 10000, units * RATE)) >> 24);
            mag = s < 0 ? -s : s;
            if (amp_q < silence_r && (mag << 9) < silence_r) begin
               sounding_q = 0; amp_q = '0; offset_q = '0;
            end
            prev_q = 16'(s);
            res.sample = 16'(s);
         end
         res.active = sounding_q;
      end
   endtask

   // result side: random stalls (none while quiet_rsp), compare in order
   always @(posedge clock) begin
      voice_out_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         if (samples_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %0d/%0b", rsp_ch.sample, rsp_ch.active);
         end else begin
            want = samples_due.pop_front();
            if (rsp_ch.sample !== want.sample || rsp_ch.active !== want.active) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %0d/%0b got %0d/%0b", want.sample,
                           want.active, rsp_ch.sample, rsp_ch.active);
            end
         end
         rsp_wait = quiet_rsp ? 0 : $urandom_range(0, 19);
         rsp_ch.ready <= (rsp_wait == 0);
      end else if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_ch.ready <= (rsp_wait == 0);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   task automatic send(input logic [1:0] mode, input logic [15:0] vel, input int gap,
                       input bit typed, input voice_out_type typed_out);
      bit has_out;
      voice_out_type res;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.mode <= mode;
      req_ch.velocity <= vel;
      do @(posedge clock); while (!req_ch.ready);
      voice_step(mode, vel, has_out, res);
      if (has_out) samples_due.push_back(typed ? typed_out : res);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (samples_due.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [15:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_TUNE:        tune_r = val;
         CSR_AMP_DECAY:   amp_ms_r = val[13:0];
         CSR_SWEEP_DEPTH: depth_r = val;
         CSR_SWEEP_DECAY: sweep_r = val;
         CSR_SILENCE:     silence_r = val;
         default: ;
      endcase
   endtask

   stim_row_type directed [] = '{
      '{MODE_TICK, 16'h0000, 1, 16'sd0, 1'b0},
      '{2'd3, 16'hFFFF, 0, 16'sd0, 1'b0},
      '{MODE_SILENCE, 16'h0000, 0, 16'sd0, 1'b0},
      '{MODE_TICK, 16'hFFFF, 1, 16'sd0, 1'b0},
      '{MODE_TRIGGER, 16'hFFFF, 0, 16'sd0, 1'b0},
      '{MODE_TICK, 16'h0000, 1, 16'sd0, 1'b1},
      '{MODE_TICK, 16'h0000, 0, 16'sd0, 1'b0},
      '{MODE_TICK, 16'h0000, 0, 16'sd0, 1'b0},
      '{MODE_TICK, 16'h0000, 0, 16'sd0, 1'b0},
      '{MODE_TICK, 16'h0000, 0, 16'sd0, 1'b0},
      '{MODE_TICK, 16'h0000, 0, 16'sd0, 1'b0},
      '{MODE_TRIGGER, 16'h0000, 0, 16'sd0, 1'b0},
      '{MODE_TICK, 16'h0000, 0, 16'sd0, 1'b0},
      '{MODE_TICK, 16'h0000, 0, 16'sd0, 1'b0},
      '{2'd3, 16'h0000, 0, 16'sd0, 1'b0},
      '{MODE_SILENCE, 16'hFFFF, 0, 16'sd0, 1'b0},
      '{MODE_TICK, 16'h0000, 1, 16'sd0, 1'b0},
      '{MODE_TRIGGER, 16'h8000, 0, 16'sd0, 1'b0},
      '{MODE_TICK, 16'h0000, 0, 16'sd0, 1'b0},
      '{MODE_TICK, 16'h0000, 0, 16'sd0, 1'b0},
      '{MODE_TICK, 16'h0000, 0, 16'sd0, 1'b0}
   };

   // tune, amp decay, sweep depth, sweep decay, silence; last value is trigger odds in %
   int phase_cfg [5][6] = '{
      '{65535, 10000, 65535, 65535, 65535, 9},
      '{0, 0, 0, 0, 0, 9},
      '{12345, 0, 40000, 9, 65535, 1},
      '{0, 1, 65535, 10, 40000, 2},
      '{-1, -1, -1, -1, -1, 8}
   };

   initial begin
      voice_out_type tv;
      int r, trig_pct;
      logic [15:0] v;
      req_ch.valid <= 1'b0;
      req_ch.mode <= MODE_TICK;
      req_ch.velocity <= '0;
      for (int i = 0; i < 1024; i++) sine_rom[i] = sine_value(i);
      voice_reset_model();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) begin
         tv.sample = directed[i].sample;
         tv.active = directed[i].active;
         send(directed[i].mode, directed[i].velocity, i % 3, directed[i].typed, tv);
      end
      for (int p = 0; p < 5; p++) begin
         drain();
         for (int c = 0; c < 5; c++) begin
            v = (phase_cfg[p][c] < 0) ? 16'($urandom_range(0, 65535)) : 16'(phase_cfg[p][c]);
            if (c == 1 && v > 10000) v = v % 16'd10001;
            csr_write(3'(c), v);
         end
         csr_we <= 1'b0;
         trig_pct = phase_cfg[p][5];
         quiet_rsp = (p == 1);
         send(MODE_TRIGGER, 16'($urandom_range(0, 65535)), 0, 0, tv);
         for (int n = 0; n < 130; n++) begin
            r = $urandom_range(0, 99);
            send(r < trig_pct ? MODE_TRIGGER : r < trig_pct + 3 ? MODE_SILENCE :
                 r < trig_pct + 5 ? 2'd3 : MODE_TICK,
                 16'($urandom_range(0, 65535)),
                 (p == 1 || (n / 20) % 4 == 3) ? 0 : $urandom_range(0, 19), 0, tv);
         end
      end
      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && samples_due.size() == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

   initial begin
      #20000000;
      $display("tb_top: FAIL");
      $finish;
   end

endmodule
`default_nettype wire
